### src/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared types and constants for the lowpass echo voice and its serial
// multiplier.
// ----------------------------------------------------------------------------
package lfe_pkg;

    localparam int MAX_DELAY_DEF       = 32768;
    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam int MUL_MC_W  = 25;
    localparam int MUL_MP_W  = 17;
    localparam int MUL_P_W   = MUL_MC_W + MUL_MP_W;
    localparam int MUL_CNT_W = $clog2(MUL_MP_W + 1);

    localparam logic [2:0] CFG_DELAY_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_FEEDBACK_GAIN = 3'd1;
    localparam logic [2:0] CFG_ECHO_MIX      = 3'd2;
    localparam logic [2:0] CFG_OUTPUT_GAIN   = 3'd3;
    localparam logic [2:0] CFG_CUTOFF_BASE   = 3'd4;
    localparam logic [2:0] CFG_CUTOFF_DEPTH  = 3'd5;
    localparam logic [2:0] CFG_LFO_STEP      = 3'd6;

    localparam logic [15:0] RST_DELAY_LENGTH  = 16'd19845;
    localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd29491;
    localparam logic [15:0] RST_ECHO_MIX      = 16'd26214;
    localparam logic [15:0] RST_OUTPUT_GAIN   = 16'd32768;
    localparam logic [15:0] RST_CUTOFF_BASE   = 16'd3932;
    localparam logic [15:0] RST_CUTOFF_DEPTH  = 16'd2621;
    localparam logic [31:0] RST_LFO_STEP      = 32'd4870;

    localparam logic [16:0] POLY_A = 17'd102944;
    localparam logic [16:0] POLY_B = 17'd42048;
    localparam logic [12:0] POLY_C = 13'd4640;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_POLY_C,
        ST_POLY_B,
        ST_POLY_A,
        ST_DEPTH,
        ST_CUT,
        ST_FB,
        ST_MIX,
        ST_GAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

### src/lfo_lowpass_feedback_echo_top.sv
// ----------------------------------------------------------------------------
// lfo_lowpass_feedback_echo_top
// LFO-swept one-pole lowpass feeding a feedback echo line.
// Each accepted input beat passes through an echo line read, nine multiplies on
// the shared serial multiplier, and a write into the output register.
// A new input beat is accepted only after the previous result has been loaded
// into the output register and the sequencer has returned to idle.
// Reset restores register defaults, zeroes filter, phase and pointer, and
// empties the echo line through a fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfo_lowpass_feedback_echo_top
    import lfe_pkg::*;
#(
    parameter int MAX_DELAY       = MAX_DELAY_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_dry_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_wet_sample
);

    localparam int PW = $clog2(MAX_DELAY);
    localparam int LW = PW + 1;

    function automatic logic [15:0] f_sat16(input logic [16:0] v);
        if (v[16] != v[15]) begin
            return v[16] ? 16'h8000 : 16'h7FFF;
        end
        return v[15:0];
    endfunction

    function automatic logic [23:0] f_sat24(input logic [26:0] v);
        if ((v[26:23] == 4'b0000) || (v[26:23] == 4'b1111)) begin
            return v[23:0];
        end
        return v[26] ? 24'h800000 : 24'h7FFFFF;
    endfunction

    logic [15:0] r_delay_length;
    logic [15:0] r_feedback_gain;
    logic [15:0] r_echo_mix;
    logic [15:0] r_output_gain;
    logic [15:0] r_cutoff_base;
    logic [15:0] r_cutoff_depth;
    logic [31:0] r_lfo_step;

    t_state r_state, n_state;
    logic   r_run, n_run;
    t_state w_op_next;
    logic   w_is_op;
    logic   w_mul_start;
    logic   w_latch;
    logic   w_accept;
    logic   w_out_free;

    logic [31:0]        r_phase;
    logic [23:0]        r_fv;
    logic [15:0]        r_lp;
    logic [15:0]        r_dry;
    logic [15:0]        r_echo;
    logic [16:0]        r_t2;
    logic [16:0]        r_p;
    logic [15:0]        r_s;
    logic [15:0]        r_cut;
    logic [16:0]        r_sum;
    logic [PW-1:0]      r_ptr;
    logic [LW-1:0]      r_fill;
    logic               r_out_valid;
    logic [15:0]        r_wet;

    logic [15:0] r_mem [MAX_DELAY];
    logic [15:0] r_mem_q;

    logic [MUL_MC_W-1:0] w_mcand;
    logic [MUL_MP_W-1:0] w_mplier;
    logic [MUL_P_W-1:0]  w_prod;
    t_mul_stat           w_mul_stat;

    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [1:0]                 w_quad;
    logic [15:0]                w_t16;
    logic [16:0]                w_t;
    logic [17:0]                w_y18;
    logic [16:0]                w_y;
    logic [15:0]                w_yh;
    logic [16:0]                w_s17;
    logic [15:0]                w_s;
    logic [16:0]                w_cut17;
    logic [24:0]                w_diff;
    logic [26:0]                w_fv_sum;
    logic [23:0]                w_fv_new;
    logic [16:0]                w_fb_sum;
    logic [16:0]                w_mix_sum;
    logic [16:0]                w_len17;
    logic [LW-1:0]              w_len;
    logic [LW-1:0]              w_ptr_ext;
    logic [LW-1:0]              w_ptr_inc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= RST_DELAY_LENGTH;
            r_feedback_gain <= RST_FEEDBACK_GAIN;
            r_echo_mix      <= RST_ECHO_MIX;
            r_output_gain   <= RST_OUTPUT_GAIN;
            r_cutoff_base   <= RST_CUTOFF_BASE;
            r_cutoff_depth  <= RST_CUTOFF_DEPTH;
            r_lfo_step      <= RST_LFO_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data[15:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[15:0];
                CFG_ECHO_MIX:      r_echo_mix      <= i_cfg_data[15:0];
                CFG_OUTPUT_GAIN:   r_output_gain   <= i_cfg_data[15:0];
                CFG_CUTOFF_BASE:   r_cutoff_base   <= i_cfg_data[15:0];
                CFG_CUTOFF_DEPTH:  r_cutoff_depth  <= i_cfg_data[15:0];
                CFG_LFO_STEP:      r_lfo_step      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective loop length and pointer arithmetic.
    always_comb begin
        if (r_delay_length == 16'd0) begin
            w_len17 = 17'd1;
        end else if ({1'b0, r_delay_length} > 17'(MAX_DELAY)) begin
            w_len17 = 17'(MAX_DELAY);
        end else begin
            w_len17 = {1'b0, r_delay_length};
        end
    end

    assign w_len     = LW'(w_len17);
    assign w_ptr_ext = {1'b0, r_ptr};
    assign w_ptr_inc = w_ptr_ext + LW'(1);

    // Sine approximation terms.
    assign w_k    = r_phase[31 -: SINE_TABLE_BITS];
    assign w_quad = w_k[SINE_TABLE_BITS-1 -: 2];
    assign w_t16  = {w_k[SINE_TABLE_BITS-3:0], {(18 - SINE_TABLE_BITS){1'b0}}};
    assign w_t    = w_quad[0] ? (17'h10000 - {1'b0, w_t16}) : {1'b0, w_t16};

    assign w_y18 = w_prod[33:16];
    assign w_y   = (w_y18 > 18'h10000) ? 17'h10000 : w_y18[16:0];
    assign w_yh  = w_y[16:1];
    assign w_s17 = 17'h08000 + {1'b0, w_yh};

    always_comb begin
        if (!w_quad[1]) begin
            w_s = w_s17[16] ? 16'hFFFF : w_s17[15:0];
        end else begin
            w_s = 16'h8000 - w_yh;
        end
    end

    assign w_cut17   = {1'b0, r_cutoff_base} + {1'b0, w_prod[31:16]};
    assign w_diff    = {r_dry[15], r_dry, 8'h00} - {r_fv[23], r_fv};
    assign w_fv_sum  = {{3{r_fv[23]}}, r_fv} + {w_prod[41], w_prod[41:16]};
    assign w_fv_new  = f_sat24(w_fv_sum);
    assign w_fb_sum  = {r_lp[15], r_lp} + {w_prod[31], w_prod[31:16]};
    assign w_mix_sum = w_fb_sum;

    // Multiplier operand selection.
    always_comb begin
        w_mcand  = '0;
        w_mplier = '0;
        case (r_state)
            ST_SQ: begin
                w_mcand  = {8'h00, w_t};
                w_mplier = w_t;
            end
            ST_POLY_C: begin
                w_mcand  = {12'h000, POLY_C};
                w_mplier = r_t2;
            end
            ST_POLY_B: begin
                w_mcand  = {8'h00, r_p};
                w_mplier = r_t2;
            end
            ST_POLY_A: begin
                w_mcand  = {8'h00, r_p};
                w_mplier = w_t;
            end
            ST_DEPTH: begin
                w_mcand  = {9'h000, r_s};
                w_mplier = {1'b0, r_cutoff_depth};
            end
            ST_CUT: begin
                w_mcand  = w_diff;
                w_mplier = {1'b0, r_cut};
            end
            ST_FB: begin
                w_mcand  = {{9{r_echo[15]}}, r_echo};
                w_mplier = {1'b0, r_feedback_gain};
            end
            ST_MIX: begin
                w_mcand  = {{9{r_echo[15]}}, r_echo};
                w_mplier = {1'b0, r_echo_mix};
            end
            ST_GAIN: begin
                w_mcand  = {{8{r_sum[16]}}, r_sum};
                w_mplier = {1'b0, r_output_gain};
            end
            default: ;
        endcase
    end

    lfe_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_product(w_prod),
        .o_stat   (w_mul_stat)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
        end
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_is_op    = r_state inside {ST_SQ, ST_POLY_C, ST_POLY_B, ST_POLY_A, ST_DEPTH,
                                        ST_CUT, ST_FB, ST_MIX, ST_GAIN};
    assign w_latch    = w_is_op && r_run && w_mul_stat.done;

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        w_op_next   = r_state;
        w_mul_start = 1'b0;
        o_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:   n_state   = ST_SQ;
            ST_SQ:     w_op_next = ST_POLY_C;
            ST_POLY_C: w_op_next = ST_POLY_B;
            ST_POLY_B: w_op_next = ST_POLY_A;
            ST_POLY_A: w_op_next = ST_DEPTH;
            ST_DEPTH:  w_op_next = ST_CUT;
            ST_CUT:    w_op_next = ST_FB;
            ST_FB:     w_op_next = ST_MIX;
            ST_MIX:    w_op_next = ST_GAIN;
            ST_GAIN:   w_op_next = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_is_op) begin
            if (!r_run) begin
                w_mul_start = 1'b1;
                n_run       = 1'b1;
            end else if (w_mul_stat.done) begin
                n_run   = 1'b0;
                n_state = w_op_next;
            end
        end
    end

    // Control-side datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_fv    <= '0;
            r_ptr   <= '0;
            r_fill  <= '0;
        end else begin
            if (w_accept) begin
                r_phase <= r_phase + r_lfo_step;
                if (w_ptr_ext >= w_len) begin
                    r_ptr <= '0;
                end
            end
            if (w_latch && (r_state == ST_CUT)) begin
                r_fv <= w_fv_new;
            end
            if (w_latch && (r_state == ST_FB) && (w_ptr_ext == r_fill)) begin
                r_fill <= r_fill + LW'(1);
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_ptr <= (w_ptr_inc >= w_len) ? '0 : w_ptr_inc[PW-1:0];
            end
        end
    end

    // Intermediate values between multiplies.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dry <= i_dry_sample;
        end
        if ((r_state == ST_SQ) && !r_run) begin
            r_echo <= (w_ptr_ext < r_fill) ? r_mem_q : 16'h0000;
        end
        if (w_latch) begin
            case (r_state)
                ST_SQ:     r_t2  <= w_prod[32:16];
                ST_POLY_C: r_p   <= POLY_B - {4'h0, w_prod[28:16]};
                ST_POLY_B: r_p   <= POLY_A - {1'b0, w_prod[31:16]};
                ST_POLY_A: r_s   <= w_s;
                ST_DEPTH:  r_cut <= w_cut17[16] ? 16'hFFFF : w_cut17[15:0];
                ST_CUT:    r_lp  <= w_fv_new[23:8];
                ST_MIX:    r_sum <= w_mix_sum;
                default: ;
            endcase
        end
    end

    // Echo line storage.
    always_ff @(posedge i_clk) begin
        if (w_latch && (r_state == ST_FB)) begin
            r_mem[r_ptr] <= f_sat16(w_fb_sum);
        end
        r_mem_q <= r_mem[r_ptr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_wet <= f_sat16(w_prod[32:16]);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_wet_sample = r_wet;

    a_ptr_within_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ptr_ext <= r_fill)
        else $error("Echo pointer is ahead of the filled region.");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("Multiplier started while busy.");

    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_stat.done |-> (r_run && w_is_op))
        else $error("Multiplier finished outside a multiply step.");

    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == ST_READ) && !r_run))
        else $error("Accepted beat did not start the echo line read.");

endmodule

### src/lfe_serial_mul.sv
// ----------------------------------------------------------------------------
// lfe_serial_mul
// Shift-and-add multiplier: a signed multiplicand times an unsigned
// multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lfe_serial_mul
    import lfe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [MUL_MC_W-1:0]        i_mcand,
    input  logic [MUL_MP_W-1:0]        i_mplier,
    output logic [MUL_P_W-1:0]         o_product,
    output t_mul_stat                  o_stat
);

    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [MUL_P_W-1:0]   r_mc;
    logic [MUL_MP_W-1:0]  r_mp;
    logic [MUL_P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= MUL_CNT_W'(MUL_MP_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= {{MUL_MP_W{i_mcand[MUL_MC_W-1]}}, i_mcand};
            r_mp  <= i_mplier;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[MUL_P_W-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[MUL_MP_W-1:1]};
        end
    end

    assign o_product   = r_acc;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

### sim/lfo_lowpass_feedback_echo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_lowpass_feedback_echo_top_tb
// Self-checking bench for the LFO-swept lowpass echo voice. A queue-fed driver
// sends dry samples. A clocked predictor tracks the filter, the LFO phase and
// the echo line. A monitor compares every wet sample with the oldest
// prediction. Directed register extremes come first, then four randomized
// phases with different idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module lfo_lowpass_feedback_echo_top_tb
    import lfe_pkg::*;
();

    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam int         HOLD_CYCLES = 1500;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         RAND_ITEMS  = 120;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [2:0]         i_cfg_idx    = CFG_DELAY_LENGTH;
    logic [31:0]        i_cfg_data   = '0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_dry_sample = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic signed [15:0] o_wet_sample;

    logic signed [15:0] dry_pending[$];
    logic signed [15:0] wet_expected[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_on        = 1'b0;
    int hold_cnt       = 0;
    int cycles         = 0;
    int errors         = 0;
    int n_checked      = 0;
    int n_cfg          = 0;

    // Predictor state and register shadows.
    int          reg_delay;
    int          reg_fb;
    int          reg_mix;
    int          reg_gain;
    int          reg_cut_base;
    int          reg_cut_depth;
    logic [31:0] reg_lfo_step;
    longint      filt_acc;
    logic [31:0] lfo_acc;
    shortint     echo_mem [MAX_DELAY_DEF];
    longint      echo_idx;

    lfo_lowpass_feedback_echo_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_dry_sample (i_dry_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_wet_sample (o_wet_sample)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic logic signed [15:0] predict_wet(input logic signed [15:0] dry);
        longint     len, t, t2, p, y, s, cut, fv, lp, echo, store, wet;
        logic [7:0] k;
        len = clamp(reg_delay, 1, MAX_DELAY_DEF);
        lfo_acc = lfo_acc + reg_lfo_step;
        k = lfo_acc[31:24];
        t = longint'(k[5:0]) << 10;
        if (k[6]) begin
            t = 65536 - t;
        end
        t2 = (t * t) >> 16;
        p = (longint'(POLY_C) * t2) >> 16;
        p = longint'(POLY_B) - p;
        p = (p * t2) >> 16;
        p = longint'(POLY_A) - p;
        y = (p * t) >> 16;
        if (y > 65536) begin
            y = 65536;
        end
        if (!k[7]) begin
            s = clamp(32768 + (y >> 1), 0, 65535);
        end else begin
            s = 32768 - (y >> 1);
        end
        cut = clamp(reg_cut_base + ((reg_cut_depth * s) >> 16), 0, 65535);
        fv = filt_acc;
        fv = fv + ((cut * (longint'(dry) * 256 - fv)) >>> 16);
        fv = clamp(fv, -8388608, 8388607);
        filt_acc = fv;
        lp = fv >>> 8;
        if (echo_idx >= len) begin
            echo_idx = 0;
        end
        echo = echo_mem[echo_idx];
        store = lp + ((echo * reg_fb) >>> 16);
        echo_mem[echo_idx] = shortint'(clamp(store, -32768, 32767));
        echo_idx = echo_idx + 1;
        if (echo_idx >= len) begin
            echo_idx = 0;
        end
        wet = ((lp + ((echo * reg_mix) >>> 16)) * reg_gain) >>> 16;
        return 16'(clamp(wet, -32768, 32767));
    endfunction

    function automatic logic [31:0] with_noise(input logic [15:0] v);
        logic [31:0] w;
        w = $urandom;
        w[15:0] = v;
        return w;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_delay();
        int r;
        r = $urandom_range(19);
        if (r < 14) begin
            return 16'($urandom_range(48, 1));
        end else if (r < 16) begin
            return 16'h0000;
        end else if (r < 18) begin
            return 16'($urandom_range(65535, 32768));
        end
        return 16'($urandom_range(4000, 49));
    endfunction

    function automatic logic signed [15:0] rand_dry();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_DELAY_LENGTH:  reg_delay     = data[15:0];
            CFG_FEEDBACK_GAIN: reg_fb        = data[15:0];
            CFG_ECHO_MIX:      reg_mix       = data[15:0];
            CFG_OUTPUT_GAIN:   reg_gain      = data[15:0];
            CFG_CUTOFF_BASE:   reg_cut_base  = data[15:0];
            CFG_CUTOFF_DEPTH:  reg_cut_depth = data[15:0];
            CFG_LFO_STEP:      reg_lfo_step  = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (dry_pending.size() != 0 || i_valid || wet_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic shuffle_regs();
        logic [31:0] step;
        case ($urandom_range(3))
            0: step = $urandom_range(20000);
            1: step = 32'hFFFF_FFFF;
            default: step = $urandom;
        endcase
        write_reg(CFG_DELAY_LENGTH,  with_noise(rand_delay()));
        write_reg(CFG_FEEDBACK_GAIN, with_noise(rand_gain()));
        write_reg(CFG_ECHO_MIX,      with_noise(rand_gain()));
        write_reg(CFG_OUTPUT_GAIN,   with_noise(rand_gain()));
        write_reg(CFG_CUTOFF_BASE,   with_noise(rand_gain()));
        write_reg(CFG_CUTOFF_DEPTH,  with_noise(rand_gain()));
        write_reg(CFG_LFO_STEP,      step);
        write_reg(CFG_UNUSED,        $urandom);
        n_cfg++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                wet_expected.push_back(predict_wet(i_dry_sample));
            end
            if (!i_valid || o_ready) begin
                if (dry_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_dry_sample <= dry_pending.pop_front();
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_on && hold_cnt < HOLD_CYCLES) begin
            hold_cnt <= hold_cnt + 1;
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (wet_expected.size() == 0) begin
                $error("wet_sample: beat with no prediction, actual %0d", o_wet_sample);
                errors++;
            end else begin
                want = wet_expected.pop_front();
                n_checked++;
                if (o_wet_sample !== want) begin
                    $error("wet_sample mismatch: expected %0d, actual %0d", want, o_wet_sample);
                    errors++;
                end
            end
        end
        if (hold_on && hold_cnt < HOLD_CYCLES) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int ph;
        int i;
        reg_delay     = RST_DELAY_LENGTH;
        reg_fb        = RST_FEEDBACK_GAIN;
        reg_mix       = RST_ECHO_MIX;
        reg_gain      = RST_OUTPUT_GAIN;
        reg_cut_base  = RST_CUTOFF_BASE;
        reg_cut_depth = RST_CUTOFF_DEPTH;
        reg_lfo_step  = RST_LFO_STEP;
        filt_acc      = 0;
        lfo_acc       = '0;
        echo_idx      = 0;
        for (i = 0; i < MAX_DELAY_DEF; i++) begin
            echo_mem[i] = 0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_cfg = 1;

        // Reset defaults with full-scale and small samples.
        dry_pending.push_back(16'sh7FFF);
        dry_pending.push_back(16'sh8000);
        dry_pending.push_back(16'sh0000);
        dry_pending.push_back(16'shFFFF);
        dry_pending.push_back(16'sh0001);
        dry_pending.push_back(16'sh5555);
        drain();

        // All gains at maximum with a one-sample loop, so stores and output saturate.
        write_reg(CFG_DELAY_LENGTH,  32'hFFFF_0001);
        write_reg(CFG_FEEDBACK_GAIN, 32'h0000_FFFF);
        write_reg(CFG_ECHO_MIX,      32'hA5A5_FFFF);
        write_reg(CFG_OUTPUT_GAIN,   32'h0000_FFFF);
        write_reg(CFG_CUTOFF_BASE,   32'h0000_FFFF);
        write_reg(CFG_CUTOFF_DEPTH,  32'h0000_FFFF);
        write_reg(CFG_LFO_STEP,      32'hFFFF_FFFF);
        n_cfg++;
        for (i = 0; i < 3; i++) begin
            dry_pending.push_back(16'sh7FFF);
        end
        for (i = 0; i < 3; i++) begin
            dry_pending.push_back(16'sh8000);
        end
        dry_pending.push_back(16'sh0000);
        dry_pending.push_back(16'sh0001);
        drain();

        // Zero length acts as one; all coefficients at zero.
        write_reg(CFG_DELAY_LENGTH,  32'h0000_0000);
        write_reg(CFG_FEEDBACK_GAIN, 32'h0000_0000);
        write_reg(CFG_ECHO_MIX,      32'h0000_0000);
        write_reg(CFG_OUTPUT_GAIN,   32'h0000_0000);
        write_reg(CFG_CUTOFF_BASE,   32'h0000_0000);
        write_reg(CFG_CUTOFF_DEPTH,  32'h0000_0000);
        write_reg(CFG_LFO_STEP,      32'h0000_0000);
        write_reg(CFG_UNUSED,        32'hFFFF_FFFF);
        n_cfg++;
        dry_pending.push_back(16'sh7FFF);
        dry_pending.push_back(16'sh8000);
        dry_pending.push_back(16'sh007B);
        drain();

        // A length above the store size acts as the full store.
        write_reg(CFG_DELAY_LENGTH,  32'h0000_FFFF);
        write_reg(CFG_OUTPUT_GAIN,   32'h0000_FFFF);
        write_reg(CFG_CUTOFF_BASE,   32'h0000_8000);
        write_reg(CFG_CUTOFF_DEPTH,  32'h0000_FFFF);
        write_reg(CFG_LFO_STEP,      32'h4000_0000);
        n_cfg++;
        dry_pending.push_back(16'sh4000);
        dry_pending.push_back(16'shC000);
        dry_pending.push_back(16'sh7FFF);
        dry_pending.push_back(16'sh8000);
        dry_pending.push_back(16'sh2AAA);
        drain();

        // Shrinking the loop below the current pointer restarts it at zero.
        write_reg(CFG_DELAY_LENGTH,  32'h0000_0003);
        write_reg(CFG_FEEDBACK_GAIN, 32'h0000_FFFF);
        write_reg(CFG_ECHO_MIX,      32'h0000_8000);
        n_cfg++;
        dry_pending.push_back(16'sh7FFF);
        dry_pending.push_back(16'sh7FFF);
        dry_pending.push_back(16'sh8000);
        dry_pending.push_back(16'sh1234);

        for (ph = 0; ph < 4; ph++) begin
            drain();
            shuffle_regs();
            case (ph)
                0: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                    hold_on        <= 1'b1;
                end
                1: begin
                    send_idle_pct  <= 55;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 55;
                end
                default: begin
                    send_idle_pct  <= 13;
                    recv_stall_pct <= 13;
                end
            endcase
            for (i = 0; i < RAND_ITEMS; i++) begin
                dry_pending.push_back(rand_dry());
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Checked %0d wet samples across %0d register settings,", n_checked, n_cfg);
        $display("with idle, stall, mixed and long hold-off handshake phases.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### lfo_lowpass_feedback_echo_top.f
src/lfe_pkg.sv
src/lfe_serial_mul.sv
src/lfo_lowpass_feedback_echo_top.sv
sim/lfo_lowpass_feedback_echo_top_tb.sv
